>>> hdl/tanrp_pkg.sv
package tanrp_pkg;

  typedef enum logic [3:0] {
    PH_TAN_LEN   = 4'd0,
    PH_TAN_DATA  = 4'd1,
    PH_CNT_LEN   = 4'd2,
    PH_CNT_DATA  = 4'd3,
    PH_SKIP_LEN  = 4'd4,
    PH_SKIP_DATA = 4'd5,
    PH_INFO_LEN  = 4'd6,
    PH_INFO_DATA = 4'd7,
    PH_IDLE      = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_TAN     = 3'd0,
    KIND_COUNTER = 3'd1,
    KIND_CARD_NO = 3'd2,
    KIND_END_DT  = 3'd3,
    KIND_ISS_DT  = 3'd4
  } kind_e;

  localparam logic [3:0] NIB_PAD     = 4'hF;
  localparam logic [5:0] POS_MAX     = 6'd63;
  localparam logic [5:0] CARD_FIRST  = 6'd8;
  localparam logic [5:0] CARD_LAST   = 6'd17;
  localparam logic [5:0] END_FIRST   = 6'd20;
  localparam logic [5:0] END_LAST    = 6'd23;
  localparam logic [5:0] ISS_FIRST   = 6'd24;
  localparam logic [5:0] ISS_LAST    = 6'd29;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  digit;
    logic [31:0] counter_value;
    logic        field_done;
    logic        last;
  } res_t;

  typedef struct packed {
    logic  vld;
    kind_e kind;
    logic  done;
  } info_map_t;

  // Which card-info digit positions produce an item, and of what kind.
  function automatic info_map_t info_map(input logic [5:0] pos);
    info_map_t m;
    m.vld  = 1'b0;
    m.kind = KIND_CARD_NO;
    m.done = 1'b0;
    if (pos >= CARD_FIRST && pos <= CARD_LAST) begin
      m.vld  = 1'b1;
      m.kind = KIND_CARD_NO;
      m.done = (pos == CARD_LAST);
    end else if (pos >= END_FIRST && pos <= END_LAST) begin
      m.vld  = 1'b1;
      m.kind = KIND_END_DT;
      m.done = (pos == END_LAST);
    end else if (pos >= ISS_FIRST && pos <= ISS_LAST) begin
      m.vld  = 1'b1;
      m.kind = KIND_ISS_DT;
      m.done = (pos == ISS_LAST);
    end
    return m;
  endfunction

  function automatic logic [5:0] pos_inc(input logic [5:0] pos);
    return (pos == POS_MAX) ? POS_MAX : pos + 6'd1;
  endfunction

endpackage

>>> hdl/tanrp_if.sv
interface tanrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface tanrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  digit;
  logic [31:0] counter_value;
  logic        field_done;
  logic        last;

  modport source (output valid, kind, digit, counter_value, field_done, last, input ready);
  modport sink   (input valid, kind, digit, counter_value, field_done, last, output ready);
endinterface

>>> hdl/tan_response_field_parser_unit.sv
// TAN response parser. Feed the card response one byte per item, with first_byte set on
// the opening byte of each response. The bytes are read as four length-prefixed fields:
// packed TAN digits (a low nibble of 0xF is padding and dropped), a big-endian
// transaction counter (size 0 still reads one byte; longer counters keep only the last
// COUNTER_WIDTH bits and report the low 32), a skipped field, and packed card info whose
// digits 8-17, 20-23 and 24-29 come out as card number, end date and issue date digits.
// Bytes after the card-info field produce nothing. Each byte gives zero, one or two
// result items; the last of them carries last=1, and the final item of a field carries
// field_done=1. Timing: the byte is parsed in the cycle it is accepted and its results
// are registered, visible in the next cycle. A byte is taken every cycle as long as the
// two-entry result register drains; since the result port moves one item per cycle, a
// byte that produces two items holds the port, and the next byte is taken only as the
// second of those items leaves.
module tan_response_field_parser_unit #(
  parameter int COUNTER_WIDTH = 32  // accumulator width, 8..64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tanrp_in_if.sink            in_i,
  tanrp_out_if.source         out_o
);
  import tanrp_pkg::*;

  // parser state
  phase_e                   phase_q, phase_d;
  logic [7:0]               bytes_left_q, bytes_left_d;
  logic [COUNTER_WIDTH-1:0] accum_q, accum_d;
  logic [5:0]               pos_q, pos_d;

  // result register: up to two items, slot 0 at the port
  res_t       res_q [2];
  res_t       res_d [2];
  logic [1:0] cnt_q, cnt_d;

  // state as seen by this byte (first_byte restarts the parser)
  phase_e                   phase_s;
  logic [7:0]               bytes_left_s;
  logic [COUNTER_WIDTH-1:0] accum_s;
  logic [5:0]               pos_s;

  logic [7:0]               bl_dec;
  logic [3:0]               hi, lo;
  logic [COUNTER_WIDTH+7:0] accum_cat;
  logic [COUNTER_WIDTH+31:0] cv_ext;
  logic [5:0]               pos_1;
  info_map_t                map_a, map_b;

  // candidate items of this byte, in order
  res_t a_res, b_res;
  logic a_vld, b_vld;
  res_t new_res [2];
  logic [1:0] new_cnt;

  logic in_fire, out_fire;

  assign out_fire = out_o.valid && out_o.ready;
  // accept when the result register is empty or its last item leaves this cycle
  assign in_i.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);
  assign in_fire  = in_i.valid && in_i.ready;

  assign hi = in_i.data_byte[7:4];
  assign lo = in_i.data_byte[3:0];

  always_comb begin
    if (in_i.first_byte) begin
      phase_s      = PH_TAN_LEN;
      bytes_left_s = '0;
      accum_s      = '0;
      pos_s        = '0;
    end else begin
      phase_s      = phase_q;
      bytes_left_s = bytes_left_q;
      accum_s      = accum_q;
      pos_s        = pos_q;
    end
  end

  assign bl_dec    = bytes_left_s - 8'd1;
  assign accum_cat = {accum_s, in_i.data_byte};
  assign cv_ext    = {32'd0, accum_cat[COUNTER_WIDTH-1:0]};
  assign pos_1     = pos_inc(pos_s);
  assign map_a     = info_map(pos_s);
  assign map_b     = info_map(pos_1);

  always_comb begin
    phase_d      = phase_s;
    bytes_left_d = bytes_left_s;
    accum_d      = accum_s;
    pos_d        = pos_s;
    a_vld        = 1'b0;
    b_vld        = 1'b0;
    a_res        = '{kind: KIND_TAN, digit: hi, counter_value: '0, field_done: 1'b0,
                     last: 1'b0};
    b_res        = '{kind: KIND_TAN, digit: lo, counter_value: '0, field_done: 1'b0,
                     last: 1'b0};
    case (phase_s)
      PH_TAN_LEN: begin
        bytes_left_d = in_i.data_byte;
        phase_d      = (in_i.data_byte != 8'd0) ? PH_TAN_DATA : PH_CNT_LEN;
      end
      PH_TAN_DATA: begin
        bytes_left_d = bl_dec;
        a_vld        = 1'b1;
        if (lo != NIB_PAD) begin
          b_vld            = 1'b1;
          b_res.field_done = (bl_dec == 8'd0);
        end else begin
          a_res.field_done = (bl_dec == 8'd0);
        end
        if (bl_dec == 8'd0) phase_d = PH_CNT_LEN;
      end
      PH_CNT_LEN: begin
        bytes_left_d = (in_i.data_byte != 8'd0) ? in_i.data_byte : 8'd1;
        accum_d      = '0;
        phase_d      = PH_CNT_DATA;
      end
      PH_CNT_DATA: begin
        accum_d      = accum_cat[COUNTER_WIDTH-1:0];
        bytes_left_d = bl_dec;
        if (bl_dec == 8'd0) begin
          a_vld               = 1'b1;
          a_res.kind          = KIND_COUNTER;
          a_res.digit         = 4'd0;
          a_res.counter_value = cv_ext[31:0];
          a_res.field_done    = 1'b1;
          phase_d             = PH_SKIP_LEN;
        end
      end
      PH_SKIP_LEN: begin
        bytes_left_d = in_i.data_byte;
        phase_d      = (in_i.data_byte != 8'd0) ? PH_SKIP_DATA : PH_INFO_LEN;
      end
      PH_SKIP_DATA: begin
        bytes_left_d = bl_dec;
        if (bl_dec == 8'd0) phase_d = PH_INFO_LEN;
      end
      PH_INFO_LEN: begin
        bytes_left_d = in_i.data_byte;
        pos_d        = '0;
        phase_d      = (in_i.data_byte != 8'd0) ? PH_INFO_DATA : PH_IDLE;
      end
      PH_INFO_DATA: begin
        a_vld            = map_a.vld;
        a_res.kind       = map_a.kind;
        a_res.field_done = map_a.done;
        if (lo != NIB_PAD) begin
          b_vld            = map_b.vld;
          b_res.kind       = map_b.kind;
          b_res.field_done = map_b.done;
          pos_d            = pos_inc(pos_1);
        end else begin
          pos_d = pos_1;
        end
        bytes_left_d = bl_dec;
        if (bl_dec == 8'd0) phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // pack the candidates to the front and flag the final one
  always_comb begin
    new_res[0] = a_res;
    new_res[1] = b_res;
    new_cnt    = 2'd0;
    if (a_vld && b_vld) begin
      new_res[1].last = 1'b1;
      new_cnt         = 2'd2;
    end else if (a_vld) begin
      new_res[0].last = 1'b1;
      new_cnt         = 2'd1;
    end else if (b_vld) begin
      new_res[0]      = b_res;
      new_res[0].last = 1'b1;
      new_cnt         = 2'd1;
    end
  end

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (in_fire) begin
      // register is empty after this cycle, load the new items
      res_d = new_res;
      cnt_d = new_cnt;
    end else if (out_fire) begin
      res_d[0] = res_q[1];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TAN_LEN;
      bytes_left_q <= '0;
      accum_q      <= '0;
      pos_q        <= '0;
      cnt_q        <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        phase_q      <= phase_d;
        bytes_left_q <= bytes_left_d;
        accum_q      <= accum_d;
        pos_q        <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.kind          = res_q[0].kind;
  assign out_o.digit         = res_q[0].digit;
  assign out_o.counter_value = res_q[0].counter_value;
  assign out_o.field_done    = res_q[0].field_done;
  assign out_o.last          = res_q[0].last;

`ifndef NO_ASSERTIONS
  // a lone item at the port ends its byte; the first of two never does
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> res_q[0].last)
    else $error("single queued item without last");

  a_pair_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !res_q[0].last)
    else $error("first of two items flagged last");

  // no byte is taken while an item would be overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (cnt_q == 2'd0 || out_fire))
    else $error("byte accepted over a pending item");
`endif

endmodule
